// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level file that checks this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/skpt_pkg.sv =====
package skpt_pkg;

    // Command codes of the input transaction.
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_SEARCH = 3'd1;
    localparam logic [2:0] CMD_UPDATE = 3'd2;
    localparam logic [2:0] CMD_ERASE  = 3'd3;
    localparam logic [2:0] CMD_LIST   = 3'd4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_LIST      = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    // One stored entry.
    typedef struct packed {
        logic [3:0][63:0] name;
        logic [31:0]      qty;
        logic [31:0]      key;
    } entry_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_INC,
        RD_IDX_DEC
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_SHIFT,
        WR_NEW,
        WR_UPD
    } wr_sel_t;

    typedef enum logic [2:0] {
        SRC_ENTRY,
        SRC_NEW,
        SRC_UPD,
        SRC_BARE,
        SRC_ZERO
    } out_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     idx_clr;
        logic     idx_inc;
        logic     idx_dec;
        logic     idx_load_count;
        logic     pos_load;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     count_inc;
        logic     count_dec;
        logic     out_load;
        out_src_t out_src;
        status_t  out_status;
        logic     out_last;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] cmd;
        logic       count_zero;
        logic       full;
        logic       idx_eq_count;
        logic       idx_p1_eq_count;
        logic       idx_p2_eq_count;
        logic       idx_m1_eq_pos;
        logic       key_less;
        logic       key_eq;
        logic       out_free;
    } stat_t;

endpackage

// ===== src/skpt_ram.sv =====
module skpt_ram #(
    parameter int WIDTH = 320,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== src/skpt_datapath.sv =====
module skpt_datapath #(
    parameter int DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  skpt_pkg::ctrl_t      ctrl,
    output skpt_pkg::stat_t      stat,
    input  logic [2:0]           cmd,
    input  logic signed [31:0]   part_number,
    input  logic signed [31:0]   quantity,
    input  logic [63:0]          name_w0,
    input  logic [63:0]          name_w1,
    input  logic [63:0]          name_w2,
    input  logic [63:0]          name_w3,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic signed [31:0]   key_out,
    output logic signed [31:0]   on_hand,
    output logic [63:0]          name_out0,
    output logic [63:0]          name_out1,
    output logic [63:0]          name_out2,
    output logic [63:0]          name_out3,
    output logic                 last
);
    import skpt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [2:0]    cmd_reg;
    entry_t        cap_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] count_reg;
    entry_t        out_reg;
    status_t       status_reg;
    logic          last_reg;
    logic          out_valid_reg;

    entry_t        rd_data;
    entry_t        wr_data;
    entry_t        upd_entry;
    entry_t        out_next;
    logic [CW-1:0] rd_idx;
    logic [CW:0]   idx_wide;

    assign idx_wide = {1'b0, idx_reg};

    // Captured input transaction.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg       <= cmd;
            cap_reg.key   <= part_number;
            cap_reg.qty   <= quantity;
            cap_reg.name  <= {name_w3, name_w2, name_w1, name_w0};
        end
    end

    // Walk index, insertion point and entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            priority if (ctrl.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (ctrl.idx_load_count)
            begin
                idx_reg <= count_reg;
            end
            else if (ctrl.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            else if (ctrl.idx_dec)
            begin
                idx_reg <= idx_reg - CW'(1);
            end
            else
            begin
                idx_reg <= idx_reg;
            end
            if (ctrl.pos_load)
            begin
                pos_reg <= idx_reg;
            end
            if (ctrl.count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (ctrl.count_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Read address selection.
    always_comb
    begin
        unique case (ctrl.rd_sel)
            RD_IDX_INC: rd_idx = idx_reg + CW'(1);
            RD_IDX_DEC: rd_idx = idx_reg - CW'(1);
            default:    rd_idx = idx_reg;
        endcase
    end

    // Entry after a quantity change.
    always_comb
    begin
        upd_entry     = rd_data;
        upd_entry.qty = rd_data.qty + cap_reg.qty;
    end

    // Write data selection.
    always_comb
    begin
        unique case (ctrl.wr_sel)
            WR_NEW:  wr_data = cap_reg;
            WR_UPD:  wr_data = upd_entry;
            default: wr_data = rd_data;
        endcase
    end

    skpt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    // Output payload selection.
    always_comb
    begin
        out_next = '0;
        unique case (ctrl.out_src)
            SRC_ENTRY: out_next = rd_data;
            SRC_NEW:   out_next = cap_reg;
            SRC_UPD:   out_next = upd_entry;
            SRC_BARE:  out_next.key = cap_reg.key;
            default:   out_next = '0;
        endcase
    end

    // Output register and its valid flag.
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_reg    <= out_next;
            status_reg <= ctrl.out_status;
            last_reg   <= ctrl.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign key_out   = out_reg.key;
    assign on_hand   = out_reg.qty;
    assign name_out0 = out_reg.name[0];
    assign name_out1 = out_reg.name[1];
    assign name_out2 = out_reg.name[2];
    assign name_out3 = out_reg.name[3];
    assign last      = last_reg;

    // Status toward the controller.
    always_comb
    begin
        stat.cmd             = cmd_reg;
        stat.count_zero      = (count_reg == '0);
        stat.full            = (count_reg == CW'(DEPTH));
        stat.idx_eq_count    = (idx_reg == count_reg);
        stat.idx_p1_eq_count = ((idx_wide + (CW+1)'(1)) == {1'b0, count_reg});
        stat.idx_p2_eq_count = ((idx_wide + (CW+1)'(2)) == {1'b0, count_reg});
        stat.idx_m1_eq_pos   = ((idx_reg - CW'(1)) == pos_reg);
        stat.key_less        = ($signed(rd_data.key) < $signed(cap_reg.key));
        stat.key_eq          = (rd_data.key == cap_reg.key);
        stat.out_free        = !out_valid_reg || !out_stall;
    end
endmodule

// ===== src/skpt_ctrl.sv =====
module skpt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  skpt_pkg::stat_t stat,
    output skpt_pkg::ctrl_t ctrl
);
    import skpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_INS_RD,
        S_INS_WR,
        S_INS_NEW,
        S_UPD,
        S_ER_EMIT,
        S_ER_RD,
        S_ER_WR,
        S_EMIT,
        S_BARE,
        S_LIST
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    hit;

    assign in_stall = (state_reg != S_IDLE);
    assign hit      = !stat.idx_eq_count && stat.key_eq;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    ctrl.idx_clr = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // Read entry zero for the scan or the listing.
                ctrl.rd_sel = RD_IDX;
                if (stat.cmd == CMD_LIST)
                begin
                    if (stat.count_zero)
                    begin
                        st_next    = ST_EMPTY;
                        state_next = S_BARE;
                    end
                    else
                    begin
                        state_next = S_LIST;
                    end
                end
                else if (stat.cmd > CMD_LIST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stat.idx_eq_count && stat.key_less)
                begin
                    ctrl.idx_inc = 1'b1;
                    ctrl.rd_sel  = RD_IDX_INC;
                end
                else
                begin
                    ctrl.rd_sel = RD_IDX;
                    unique case (stat.cmd)
                        CMD_INSERT:
                        begin
                            priority if (stat.full)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_BARE;
                            end
                            else if (hit)
                            begin
                                st_next    = ST_EXISTS;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                ctrl.pos_load       = 1'b1;
                                ctrl.idx_load_count = 1'b1;
                                state_next = stat.idx_eq_count ? S_INS_NEW : S_INS_RD;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            st_next    = hit ? ST_OK : ST_NOT_FOUND;
                            state_next = hit ? S_EMIT : S_BARE;
                        end
                        CMD_UPDATE:
                        begin
                            st_next    = ST_NOT_FOUND;
                            state_next = hit ? S_UPD : S_BARE;
                        end
                        default:
                        begin
                            st_next    = ST_NOT_FOUND;
                            state_next = hit ? S_ER_EMIT : S_BARE;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                ctrl.rd_sel = RD_IDX_DEC;
                state_next  = S_INS_WR;
            end
            S_INS_WR:
            begin
                // Move the entry below up by one place.
                ctrl.wr_en   = 1'b1;
                ctrl.wr_sel  = WR_SHIFT;
                ctrl.idx_dec = 1'b1;
                state_next   = stat.idx_m1_eq_pos ? S_INS_NEW : S_INS_RD;
            end
            S_INS_NEW:
            begin
                if (stat.out_free)
                begin
                    ctrl.wr_en      = 1'b1;
                    ctrl.wr_sel     = WR_NEW;
                    ctrl.count_inc  = 1'b1;
                    ctrl.out_load   = 1'b1;
                    ctrl.out_src    = SRC_NEW;
                    ctrl.out_status = ST_OK;
                    ctrl.out_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_UPD:
            begin
                ctrl.rd_sel = RD_IDX;
                if (stat.out_free)
                begin
                    ctrl.wr_en      = 1'b1;
                    ctrl.wr_sel     = WR_UPD;
                    ctrl.out_load   = 1'b1;
                    ctrl.out_src    = SRC_UPD;
                    ctrl.out_status = ST_OK;
                    ctrl.out_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_ER_EMIT:
            begin
                ctrl.rd_sel = RD_IDX;
                if (stat.out_free)
                begin
                    ctrl.out_load   = 1'b1;
                    ctrl.out_src    = SRC_ENTRY;
                    ctrl.out_status = ST_OK;
                    ctrl.out_last   = 1'b1;
                    if (stat.idx_p1_eq_count)
                    begin
                        ctrl.count_dec = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ER_RD;
                    end
                end
            end
            S_ER_RD:
            begin
                ctrl.rd_sel = RD_IDX_INC;
                state_next  = S_ER_WR;
            end
            S_ER_WR:
            begin
                // Move the entry above down by one place.
                ctrl.wr_en   = 1'b1;
                ctrl.wr_sel  = WR_SHIFT;
                ctrl.idx_inc = 1'b1;
                if (stat.idx_p2_eq_count)
                begin
                    ctrl.count_dec = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_ER_RD;
                end
            end
            S_EMIT:
            begin
                ctrl.rd_sel = RD_IDX;
                if (stat.out_free)
                begin
                    ctrl.out_load   = 1'b1;
                    ctrl.out_src    = SRC_ENTRY;
                    ctrl.out_status = st_reg;
                    ctrl.out_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_BARE:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load   = 1'b1;
                    ctrl.out_src    = (st_reg == ST_EMPTY) ? SRC_ZERO : SRC_BARE;
                    ctrl.out_status = st_reg;
                    ctrl.out_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LIST:
            begin
                ctrl.rd_sel = RD_IDX;
                if (stat.out_free)
                begin
                    ctrl.out_load   = 1'b1;
                    ctrl.out_src    = SRC_ENTRY;
                    ctrl.out_status = ST_LIST;
                    ctrl.out_last   = stat.idx_p1_eq_count;
                    if (stat.idx_p1_eq_count)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctrl.idx_inc = 1'b1;
                        ctrl.rd_sel  = RD_IDX_INC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the held reply status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end
endmodule

// ===== src/sorted_keyed_parts_table.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_stall    | cmd, part_number, quantity, name_w0..3
// out     | output    | out_valid / out_stall  | status, key_out, on_hand, name_out0..3, last
//
// A command is taken in S_IDLE, decoded in S_DECODE, scans in S_SCAN past each entry
// below its key, and then loads its result into the output register. An insert moves
// each entry up through S_INS_RD and S_INS_WR, an erase each entry down through S_ER_RD
// and S_ER_WR; a list gives one result per cycle while out_stall stays low.
// Reset clears the entry count and all control; the entry memory is not cleared.
// in_stall is high from the accepting edge until idle; a held result delays the load.
module sorted_keyed_parts_table #(
    parameter int DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] part_number,
    input  logic signed [31:0] quantity,
    input  logic [63:0]        name_w0,
    input  logic [63:0]        name_w1,
    input  logic [63:0]        name_w2,
    input  logic [63:0]        name_w3,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] key_out,
    output logic signed [31:0] on_hand,
    output logic [63:0]        name_out0,
    output logic [63:0]        name_out1,
    output logic [63:0]        name_out2,
    output logic [63:0]        name_out3,
    output logic               last
);
    import skpt_pkg::*;

`include "assert_macros.svh"

    ctrl_t ctrl;
    stat_t stat;

    skpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    skpt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .cmd         (cmd),
        .part_number (part_number),
        .quantity    (quantity),
        .name_w0     (name_w0),
        .name_w1     (name_w1),
        .name_w2     (name_w2),
        .name_w3     (name_w3),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .key_out     (key_out),
        .on_hand     (on_hand),
        .name_out0   (name_out0),
        .name_out1   (name_out1),
        .name_out2   (name_out2),
        .name_out3   (name_out3),
        .last        (last)
    );

    // Checks on the controller and datapath interplay.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_SAME(a_load_when_free, clk, rst_n, ctrl.out_load, !out_valid || !out_stall)
    `ASSERT_SAME(a_no_insert_when_full, clk, rst_n, ctrl.count_inc, !stat.full)
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import skpt_pkg::*;

    localparam int DEPTH = 32;
    localparam int CMD_UNUSED = 5;
    localparam longint MAX_CYCLES = 2000000;

    // One result of the table.
    typedef struct {
        logic [2:0]  st;
        logic [31:0] key;
        logic [31:0] qty;
        logic [63:0] nm [4];
        logic        lst;
    } reply_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] cmd;
    logic signed [31:0] part_number;
    logic signed [31:0] quantity;
    logic [63:0] name_w0, name_w1, name_w2, name_w3;
    logic out_valid;
    logic out_stall;
    logic [2:0] status;
    logic signed [31:0] key_out;
    logic signed [31:0] on_hand;
    logic [63:0] name_out0, name_out1, name_out2, name_out3;
    logic last;

    // Shadow copy of the parts table.
    logic [31:0] shadow_key [DEPTH];
    logic [31:0] shadow_qty [DEPTH];
    logic [63:0] shadow_name [DEPTH][4];
    int          shadow_count;

    reply_t expected_replies [$];
    int     error_count;
    longint cycle_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_receiver;

    sorted_keyed_parts_table #(.DEPTH(DEPTH)) dut (.*);

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit watchdog.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLES)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic reply_t entry_reply(input logic [2:0] st, input int i,
                                           input logic lst);
        reply_t r;
        r.st = st;
        r.key = shadow_key[i];
        r.qty = shadow_qty[i];
        for (int w = 0; w < 4; w++)
            r.nm[w] = shadow_name[i][w];
        r.lst = lst;
        return r;
    endfunction

    function automatic reply_t bare_reply(input logic [2:0] st, input logic [31:0] k);
        reply_t r;
        r.st = st;
        r.key = k;
        r.qty = '0;
        for (int w = 0; w < 4; w++)
            r.nm[w] = '0;
        r.lst = 1'b1;
        return r;
    endfunction

    function automatic void shadow_move(input int dst, input int src);
        shadow_key[dst] = shadow_key[src];
        shadow_qty[dst] = shadow_qty[src];
        for (int w = 0; w < 4; w++)
            shadow_name[dst][w] = shadow_name[src][w];
    endfunction

    // Applies one command to the shadow table and queues its replies.
    function automatic void predict_table(input logic [2:0] c, input logic [31:0] k,
                                          input logic [31:0] q, input logic [63:0] n [4]);
        int  pos;
        bit  hit;
        pos = 0;
        if (c == CMD_LIST)
        begin
            if (shadow_count == 0)
                expected_replies.push_back(bare_reply(ST_EMPTY, '0));
            for (int i = 0; i < shadow_count; i++)
                expected_replies.push_back(entry_reply(ST_LIST, i, i + 1 == shadow_count));
            return;
        end
        if (c > CMD_LIST)
            return;
        while (pos < shadow_count && $signed(shadow_key[pos]) < $signed(k))
            pos++;
        hit = pos < shadow_count && shadow_key[pos] == k;
        case (c)
            CMD_INSERT:
            begin
                if (shadow_count >= DEPTH)
                    expected_replies.push_back(bare_reply(ST_FULL, k));
                else if (hit)
                    expected_replies.push_back(entry_reply(ST_EXISTS, pos, 1'b1));
                else
                begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow_move(i, i - 1);
                    shadow_key[pos] = k;
                    shadow_qty[pos] = q;
                    for (int w = 0; w < 4; w++)
                        shadow_name[pos][w] = n[w];
                    shadow_count++;
                    expected_replies.push_back(entry_reply(ST_OK, pos, 1'b1));
                end
            end
            CMD_SEARCH:
            begin
                if (!hit)
                    expected_replies.push_back(bare_reply(ST_NOT_FOUND, k));
                else
                    expected_replies.push_back(entry_reply(ST_OK, pos, 1'b1));
            end
            CMD_UPDATE:
            begin
                if (!hit)
                    expected_replies.push_back(bare_reply(ST_NOT_FOUND, k));
                else
                begin
                    shadow_qty[pos] = shadow_qty[pos] + q;
                    expected_replies.push_back(entry_reply(ST_OK, pos, 1'b1));
                end
            end
            default:
            begin
                if (!hit)
                    expected_replies.push_back(bare_reply(ST_NOT_FOUND, k));
                else
                begin
                    expected_replies.push_back(entry_reply(ST_OK, pos, 1'b1));
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_move(i, i + 1);
                    shadow_count--;
                end
            end
        endcase
    endfunction

    // Sends one transaction, with an optional random idle gap first.
    task automatic send_command(input logic [2:0] c, input logic [31:0] k,
                                input logic [31:0] q, input logic [63:0] n [4]);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        cmd <= c;
        part_number <= k;
        quantity <= q;
        name_w0 <= n[0];
        name_w1 <= n[1];
        name_w2 <= n[2];
        name_w3 <= n[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_table(c, k, q, n);
        in_valid <= 1'b0;
        // The block is busy after taking a transaction.
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4 * DEPTH + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return $urandom_range(40) - 20;
        endcase
    endfunction

    task automatic send_random(input int weight_insert);
        logic [63:0] n [4];
        logic [2:0]  c;
        int          r;
        for (int w = 0; w < 4; w++)
            n[w] = {$urandom(), $urandom()};
        r = $urandom_range(99);
        if (r < weight_insert)
            c = CMD_INSERT;
        else if (r < 97)
            c = 3'($urandom_range(CMD_SEARCH, CMD_LIST));
        else
            c = 3'($urandom_range(CMD_UNUSED, 7));
        send_command(c, rand_key(), $urandom(), n);
    endtask

    // Result checker.
    initial
    begin
        reply_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(status), '0);
                end
                else
                begin
                    e = expected_replies.pop_front();
                    if (status !== e.st)
                        report_mismatch("status", 64'(status), 64'(e.st));
                    if (key_out !== e.key)
                        report_mismatch("key_out", 64'(key_out), 64'(e.key));
                    if (on_hand !== e.qty)
                        report_mismatch("on_hand", 64'(on_hand), 64'(e.qty));
                    if (name_out0 !== e.nm[0]) report_mismatch("name0", name_out0, e.nm[0]);
                    if (name_out1 !== e.nm[1]) report_mismatch("name1", name_out1, e.nm[1]);
                    if (name_out2 !== e.nm[2]) report_mismatch("name2", name_out2, e.nm[2]);
                    if (name_out3 !== e.nm[3]) report_mismatch("name3", name_out3, e.nm[3]);
                    if (last !== e.lst)
                        report_mismatch("last", 64'(last), 64'(e.lst));
                end
            end
        end
    end

    // Receiver stall driver, with a long hold-off on request.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Directed checks of edges and special cases.
    task automatic test_directed();
        logic [63:0] n [4];
        logic [63:0] z [4];
        for (int w = 0; w < 4; w++)
        begin
            n[w] = '1;
            z[w] = '0;
        end
        send_command(CMD_LIST, 0, 0, z);
        send_command(CMD_SEARCH, 5, 0, z);
        send_command(CMD_UPDATE, 5, 1, z);
        send_command(CMD_ERASE, 5, 0, z);
        send_command(CMD_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, n);
        send_command(CMD_INSERT, 32'h8000_0000, 32'h8000_0000, z);
        send_command(CMD_INSERT, 0, 0, n);
        send_command(CMD_INSERT, 0, 7, z);
        send_command(CMD_UPDATE, 32'h7fff_ffff, 1, z);
        send_command(CMD_UPDATE, 0, 32'hffff_ffff, z);
        send_command(CMD_SEARCH, 32'h8000_0000, 0, z);
        send_command(3'(CMD_UNUSED), 0, 0, n);
        send_command(3'd7, 0, 0, n);
        send_command(CMD_LIST, 0, 0, z);
        send_command(CMD_ERASE, 0, 0, z);
        send_command(CMD_ERASE, 0, 0, z);
        send_command(CMD_LIST, 0, 0, z);
        wait_drained();
    endtask

    // Starts filling the table while the receiver holds off, then checks the full case.
    task automatic test_fill_and_backpressure();
        logic [63:0] n [4];
        hold_receiver = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_receiver = 1'b0;
            end
        join_none
        for (int i = 0; i < DEPTH + 3; i++)
        begin
            for (int w = 0; w < 4; w++)
                n[w] = {$urandom(), $urandom()};
            send_command(CMD_INSERT, $urandom(), $urandom(), n);
        end
        send_command(CMD_LIST, 0, 0, n);
        wait_drained();
        // Empty the table again, erasing at random positions.
        while (shadow_count > 0)
            send_command(CMD_ERASE, shadow_key[$urandom_range(shadow_count - 1)], 0, n);
        wait_drained();
    endtask

    task automatic test_random(input int items);
        for (int i = 0; i < items; i++)
            send_random(shadow_count < 20 ? 45 : 15);
    endtask

    initial
    begin
        logic [63:0] z [4];
        error_count = 0;
        shadow_count = 0;
        hold_receiver = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 70;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        cmd <= '0;
        part_number <= '0;
        quantity <= '0;
        name_w0 <= '0;
        name_w1 <= '0;
        name_w2 <= '0;
        name_w3 <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_backpressure();
        test_random(25);
        send_idle_pct = 70;
        recv_idle_pct = 30;
        test_random(25);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(25);
        for (int w = 0; w < 4; w++)
            z[w] = '0;
        send_command(CMD_LIST, 0, 0, z);
        wait_drained();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
